@@ rtl/core/anbs_pkg.sv @@
// ----------------------------------------------------------------------------
// anbs_pkg
// Shared types, constants and helpers of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package anbs_pkg;

    // Byte and field widths.
    localparam int BYTE_W = 8;
    localparam int TYPE_W = 5;

    // The header byte carries the unit type in its low five bits.
    localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h1F;

    // The default dropped unit type is the access unit delimiter.
    localparam logic [TYPE_W-1:0] DEFAULT_DROP_TYPE = 5'd9;

    // Configuration register indexes.
    localparam logic [7:0] REG_DROP_ENABLE = 8'd0;
    localparam logic [7:0] REG_DROP_TYPE   = 8'd1;

    // Start code bytes.
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] ONE_BYTE  = 8'h01;

    // Results that one input byte can cause at most.
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Output queue sizing.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Zero run codes of the holdback counter.
    localparam logic [1:0] HCNT_NONE  = 2'd0;
    localparam logic [1:0] HCNT_ONE   = 2'd1;
    localparam logic [1:0] HCNT_TWO   = 2'd2;
    localparam logic [1:0] HCNT_THREE = 2'd3;

    // One output beat.
    typedef struct packed {
        logic              last;
        logic              first;
        logic [TYPE_W-1:0] nal_type;
        logic [BYTE_W-1:0] data;
    } result_t;

    // Parser status, seen by the top level.
    typedef struct packed {
        logic inside_unit;
        logic awaiting_header;
    } parse_status_t;

    // Queue status, seen by the top level.
    typedef struct packed {
        logic              space_ok;
        logic [QCNT_W-1:0] level;
    } queue_status_t;

    // Builds one result beat.
    function automatic result_t make_result(
        input logic [BYTE_W-1:0] data,
        input logic [TYPE_W-1:0] nal_type,
        input logic              first,
        input logic              last
    );
        result_t r;
        r.data     = data;
        r.nal_type = nal_type;
        r.first    = first;
        r.last     = last;
        return r;
    endfunction

endpackage

@@ rtl/core/anbs_parser.sv @@
// ----------------------------------------------------------------------------
// anbs_parser
// Start code tracking, holdback of the last content byte and unit dropping.
// ----------------------------------------------------------------------------
module anbs_parser
    import anbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [7:0]              cfg_index,
    input  logic [7:0]              cfg_data,
    input  logic                    item_accept,
    input  logic [BYTE_W-1:0]       item_byte,
    input  logic                    item_eos,
    output result_t                 res [MAX_RESULTS],
    output logic [RES_CNT_W-1:0]    res_count,
    output parse_status_t           status
);

    logic              drop_enable_reg;
    logic [TYPE_W-1:0] drop_type_reg;

    logic [BYTE_W-1:0] held_reg,   held_next;
    logic [1:0]        hcnt_reg,   hcnt_next;
    logic              inside_reg, inside_next;
    logic              await_reg,  await_next;
    logic              drop_reg,   drop_next;
    logic [TYPE_W-1:0] type_reg,   type_next;
    logic              first_reg,  first_next;
    logic [RES_CNT_W-1:0] n;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_enable_reg <= 1'b1;
            drop_type_reg   <= DEFAULT_DROP_TYPE;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_DROP_ENABLE)
                drop_enable_reg <= cfg_data[0];
            else if (cfg_index == REG_DROP_TYPE)
                drop_type_reg <= cfg_data[TYPE_W-1:0];
        end
    end

    // One byte of parsing: next state and the results it causes.
    always_comb
    begin
        held_next  = held_reg;
        hcnt_next  = hcnt_reg;
        inside_next = inside_reg;
        await_next = await_reg;
        drop_next  = drop_reg;
        type_next  = type_reg;
        first_next = first_reg;
        n          = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
            res[i] = '0;

        if (item_accept)
        begin
            if (await_reg)
            begin
                // The byte after a start code is the unit header.
                await_next  = 1'b0;
                inside_next = 1'b1;
                type_next   = item_byte[TYPE_W-1:0] & NAL_TYPE_MASK[TYPE_W-1:0];
                drop_next   = drop_enable_reg &&
                              (item_byte[TYPE_W-1:0] == drop_type_reg);
                held_next   = item_byte;
                hcnt_next   = HCNT_ONE;
                first_next  = 1'b1;
            end
            else if (inside_reg)
            begin
                if (item_byte == ZERO_BYTE)
                begin
                    if (hcnt_reg == HCNT_THREE)
                    begin
                        // Third zero: the unit ends before the zero run.
                        if (!drop_reg)
                        begin
                            res[n[RES_IDX_W-1:0]] = make_result(held_reg, type_reg,
                                                                first_reg, 1'b1);
                            n = n + RES_CNT_W'(1);
                        end
                        inside_next = 1'b0;
                        drop_next   = 1'b0;
                        first_next  = 1'b0;
                        held_next   = ZERO_BYTE;
                        hcnt_next   = HCNT_TWO;
                    end
                    else
                    begin
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
                else if (item_byte == ONE_BYTE && hcnt_reg == HCNT_THREE)
                begin
                    // Start code inside a unit closes it.
                    if (!drop_reg)
                    begin
                        res[n[RES_IDX_W-1:0]] = make_result(held_reg, type_reg,
                                                            first_reg, 1'b1);
                        n = n + RES_CNT_W'(1);
                    end
                    inside_next = 1'b0;
                    drop_next   = 1'b0;
                    first_next  = 1'b0;
                    held_next   = ZERO_BYTE;
                    hcnt_next   = HCNT_NONE;
                    await_next  = 1'b1;
                end
                else
                begin
                    // Content byte: release the held byte and its zeros.
                    if (!drop_reg)
                    begin
                        res[n[RES_IDX_W-1:0]] = make_result(held_reg, type_reg,
                                                            first_reg, 1'b0);
                        n = n + RES_CNT_W'(1);
                        if (hcnt_reg != HCNT_ONE)
                        begin
                            res[n[RES_IDX_W-1:0]] = make_result(ZERO_BYTE, type_reg,
                                                                1'b0, 1'b0);
                            n = n + RES_CNT_W'(1);
                        end
                        if (hcnt_reg == HCNT_THREE)
                        begin
                            res[n[RES_IDX_W-1:0]] = make_result(ZERO_BYTE, type_reg,
                                                                1'b0, 1'b0);
                            n = n + RES_CNT_W'(1);
                        end
                    end
                    first_next = 1'b0;
                    held_next  = item_byte;
                    hcnt_next  = HCNT_ONE;
                end
            end
            else
            begin
                // Hunting for a start code.
                if (item_byte == ZERO_BYTE)
                begin
                    if (hcnt_reg != HCNT_TWO && hcnt_reg != HCNT_THREE)
                        hcnt_next = hcnt_reg + 2'd1;
                end
                else if (item_byte == ONE_BYTE &&
                         (hcnt_reg == HCNT_TWO || hcnt_reg == HCNT_THREE))
                begin
                    hcnt_next  = HCNT_NONE;
                    await_next = 1'b1;
                end
                else
                begin
                    hcnt_next = HCNT_NONE;
                end
            end

            // End of stream closes the open unit and clears the state.
            if (item_eos)
            begin
                if (inside_next && !drop_next)
                begin
                    res[n[RES_IDX_W-1:0]] = make_result(held_next, type_next,
                                                        first_next, 1'b1);
                    n = n + RES_CNT_W'(1);
                end
                held_next   = ZERO_BYTE;
                hcnt_next   = HCNT_NONE;
                inside_next = 1'b0;
                await_next  = 1'b0;
                drop_next   = 1'b0;
                type_next   = '0;
                first_next  = 1'b0;
            end
        end
    end

    assign res_count = n;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= ZERO_BYTE;
            hcnt_reg   <= HCNT_NONE;
            inside_reg <= 1'b0;
            await_reg  <= 1'b0;
            drop_reg   <= 1'b0;
            type_reg   <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            held_reg   <= held_next;
            hcnt_reg   <= hcnt_next;
            inside_reg <= inside_next;
            await_reg  <= await_next;
            drop_reg   <= drop_next;
            type_reg   <= type_next;
            first_reg  <= first_next;
        end
    end

    assign status.inside_unit     = inside_reg;
    assign status.awaiting_header = await_reg;

endmodule

@@ rtl/core/anbs_queue.sv @@
// ----------------------------------------------------------------------------
// anbs_queue
// Result queue: takes up to four beats a cycle, gives one beat a cycle while head_ready is high.
// ----------------------------------------------------------------------------
module anbs_queue
    import anbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  result_t              push_res [MAX_RESULTS],
    input  logic [RES_CNT_W-1:0] push_count,
    output result_t              head,
    output logic                 head_valid,
    input  logic                 head_ready,
    output queue_status_t        status
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Each entry picks its beat by its offset from the write pointer.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            logic [QPTR_W-1:0] off;
            off = QPTR_W'(j) - wr_ptr_reg;
            if ({1'b0, off} < (QPTR_W+1)'(push_count))
                entry_reg[j] <= push_res[off[RES_IDX_W-1:0]];
        end
    end

    // Room for the largest burst that one byte can cause.
    assign status.space_ok = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign status.level    = count_reg;

endmodule

@@ rtl/core/annexb_nal_unit_splitter.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex B byte stream into NAL unit bytes with type and flags.
// ----------------------------------------------------------------------------
// Result beats are written into the queue when the byte that causes them is
// accepted, and are offered on the master side in order from its head.
// Throughput: one byte per cycle; a byte releases up to four beats into an
// eight-entry queue, and the slave side stalls while more than four are queued.
// Reset: unit tracking is cleared, drop_enable resets to 1 and drop_type to 9.
module annexb_nal_unit_splitter
    import anbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Slave side.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_stream
    // Master side.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [5:0]  m_tuser,    // [4:0] nal_type, [5] nal_first
    output logic        m_tlast     // nal_last
);

    result_t              res [MAX_RESULTS];
    logic [RES_CNT_W-1:0] res_count;
    parse_status_t        pstat;
    queue_status_t        qstat;
    result_t              head;
    logic                 item_accept;

    // Configuration is always taken.
    assign cfg_ready   = 1'b1;
    assign s_tready    = qstat.space_ok;
    assign item_accept = s_tvalid && s_tready;

    anbs_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .item_byte   (s_tdata),
        .item_eos    (s_tlast),
        .res         (res),
        .res_count   (res_count),
        .status      (pstat)
    );

    anbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_res   (res),
        .push_count (res_count),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .status     (qstat)
    );

    // Output beat fields.
    assign m_tdata = head.data;
    assign m_tuser = {head.first, head.nal_type};
    assign m_tlast = head.last;

`ifndef SYNTHESIS
    // The queue never holds more beats than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.level <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A byte is taken only while the queue has room for a full burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |-> qstat.level <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS))
        else $error("byte accepted without queue room");

    // End of stream leaves no open unit and no pending header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && s_tlast) |=> (!pstat.inside_unit && !pstat.awaiting_header))
        else $error("state not cleared after end of stream");

    // A unit cannot be open while its header is still awaited.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pstat.inside_unit && pstat.awaiting_header))
        else $error("inside unit while awaiting header");
`endif

endmodule

@@ sim/nal_split_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nal_split_checker
// Watches the configuration, slave and master channels of the Annex B NAL
// unit splitter. It keeps its own model of the start code parser, works out
// the unit bytes that each accepted stream byte releases, and compares every
// master beat field by field with the oldest unit byte still due.
// ----------------------------------------------------------------------------
module nal_split_checker
    import anbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    input  logic [5:0]        m_tuser,
    input  logic              m_tlast,
    output int unsigned       pending,
    output int unsigned       fail_count
);

    // Copy of the drop registers.
    logic              drop_en;
    logic [TYPE_W-1:0] drop_ty;

    // Parser state: held content byte, zero run, unit tracking.
    logic [BYTE_W-1:0] held_byte;
    logic [2:0]        held_cnt;
    logic              in_unit;
    logic              want_header;
    logic              skip_unit;
    logic [TYPE_W-1:0] unit_type;
    logic              held_is_header;

    // Unit bytes released by the parser and not yet seen on the master side.
    result_t           unit_bytes_due[$];
    result_t           due;
    int unsigned       errors = 0;
    int unsigned       beat_no = 0;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 20)
            $display("nal_split_checker: beat %0d: %s", beat_no, what);
    endtask

    task automatic clear_parser();
        held_byte      = ZERO_BYTE;
        held_cnt       = '0;
        in_unit        = 1'b0;
        want_header    = 1'b0;
        skip_unit      = 1'b0;
        unit_type      = '0;
        held_is_header = 1'b0;
    endtask

    // A byte of a unit that is being dropped releases nothing.
    task automatic queue_unit_byte(input logic [BYTE_W-1:0] b, input logic first,
                                   input logic last);
        result_t r;
        if (!skip_unit)
        begin
            r.data     = b;
            r.nal_type = unit_type;
            r.first    = first;
            r.last     = last;
            unit_bytes_due.push_back(r);
        end
    endtask

    // The held byte becomes the last byte of the unit.
    task automatic end_unit();
        queue_unit_byte(held_byte, held_is_header, 1'b1);
        in_unit        = 1'b0;
        skip_unit      = 1'b0;
        held_is_header = 1'b0;
        held_byte      = ZERO_BYTE;
        held_cnt       = '0;
    endtask

    task automatic split_stream_byte(input logic [BYTE_W-1:0] b, input logic eos);
        logic [2:0] zeros;
        if (want_header)
        begin
            // First byte after a start code is the header.
            want_header    = 1'b0;
            in_unit        = 1'b1;
            unit_type      = TYPE_W'(b & NAL_TYPE_MASK);
            skip_unit      = drop_en && (TYPE_W'(b & NAL_TYPE_MASK) == drop_ty);
            held_byte      = b;
            held_cnt       = 3'd1;
            held_is_header = 1'b1;
        end
        else if (in_unit)
        begin
            zeros = held_cnt - 3'd1;
            if (zeros > 3'd2)
                zeros = 3'd2;
            if (b == ZERO_BYTE)
            begin
                // A third zero ends the unit; the run keeps counting outside.
                if (zeros >= 3'd2)
                begin
                    end_unit();
                    held_cnt = 3'd2;
                end
                else
                    held_cnt = zeros + 3'd2;
            end
            else if (b == ONE_BYTE && zeros >= 3'd2)
            begin
                end_unit();
                want_header = 1'b1;
            end
            else
            begin
                // The held byte and the held zeros turn out to be content.
                queue_unit_byte(held_byte, held_is_header, 1'b0);
                held_is_header = 1'b0;
                for (int k = 0; k < zeros; k++)
                    queue_unit_byte(ZERO_BYTE, 1'b0, 1'b0);
                held_byte = b;
                held_cnt  = 3'd1;
            end
        end
        else
        begin
            // Hunting for a start code.
            if (b == ZERO_BYTE)
            begin
                if (held_cnt < 3'd2)
                    held_cnt++;
            end
            else if (b == ONE_BYTE && held_cnt >= 3'd2)
            begin
                held_cnt    = '0;
                want_header = 1'b1;
            end
            else
                held_cnt = '0;
        end

        // End of stream closes the open unit and restarts the parser.
        if (eos)
        begin
            if (in_unit)
                end_unit();
            clear_parser();
        end
    endtask

    // Master beats are checked before the byte of the same edge is modeled:
    // a beat always comes from a byte accepted on an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            drop_en = 1'b1;
            drop_ty = DEFAULT_DROP_TYPE;
            unit_bytes_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (unit_bytes_due.size() == 0)
                    report_mismatch($sformatf("unexpected beat data=%02h user=%02h last=%0b",
                                              m_tdata, m_tuser, m_tlast));
                else
                begin
                    due = unit_bytes_due.pop_front();
                    if (m_tdata !== due.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_tdata, due.data));
                    if (m_tuser[4:0] !== due.nal_type)
                        report_mismatch($sformatf("nal_type %0d, expected %0d",
                                                  m_tuser[4:0], due.nal_type));
                    if (m_tuser[5] !== due.first)
                        report_mismatch($sformatf("nal_first %b, expected %b",
                                                  m_tuser[5], due.first));
                    if (m_tlast !== due.last)
                        report_mismatch($sformatf("nal_last %b, expected %b",
                                                  m_tlast, due.last));
                end
                beat_no++;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DROP_ENABLE)
                    drop_en = cfg_data[0];
                else if (cfg_index == REG_DROP_TYPE)
                    drop_ty = cfg_data[TYPE_W-1:0];
            end

            if (s_tvalid && s_tready)
                split_stream_byte(s_tdata, s_tlast);
        end
        pending    <= unit_bytes_due.size();
        fail_count <= errors;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the Annex B NAL unit splitter. A short directed stream covers
// junk before the first start code, both start code lengths, zero runs inside
// a unit, a dropped delimiter, a zero header and end of stream; random streams
// of well-formed units with noise follow under several drop settings. The
// sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
    import anbs_pkg::*;

    localparam logic [7:0] REG_UNUSED     = 8'd2;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         WATCHDOG_LIMIT = 500;
    localparam int         PHASE_BYTES    = 50;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_index = 8'd0;
    logic [7:0]        cfg_data  = 8'd0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'd0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic [5:0]        m_tuser;
    logic              m_tlast;

    int unsigned       pending;
    int unsigned       fail_count;

    logic              drain     = 1'b0;
    logic [9:0]        rx_cycle  = '0;
    logic [TYPE_W-1:0] drop_type_now = DEFAULT_DROP_TYPE;
    int unsigned       burst_left   = 0;
    int unsigned       random_beats = 0;
    int unsigned       in_beats     = 0;
    int unsigned       out_beats    = 0;
    int unsigned       cfg_writes   = 0;
    int unsigned       quiet        = 0;

    annexb_nal_unit_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    nal_split_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: ready pattern changes with the upper bits of its cycle counter; always ready while draining.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 10'd1;
        if (m_tvalid && m_tready)
            out_beats++;
        if (drain)
            m_tready <= 1'b1;
        else
        begin
            case (rx_cycle[7:6])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= (rx_cycle[2:0] < 3'd3);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: no beat moved for %0d cycles", quiet);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Sends one stream byte; a new burst starts with a random gap.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        in_beats++;
    endtask

    // Random stream byte, now and then marked as end of stream.
    task automatic stream_byte(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 59) == 0);
        random_beats++;
    endtask

    // Waits until every due unit byte has come out, then lets the bench settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge clk);
    endtask

    // One NAL unit with random content, sometimes preceded by noise.
    task automatic send_unit();
        int len;
        logic [7:0] hdr;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) stream_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            stream_byte(ZERO_BYTE);
        stream_byte(ZERO_BYTE);
        stream_byte(ZERO_BYTE);
        stream_byte(ONE_BYTE);
        case ($urandom_range(0, 7))
            0, 1:    hdr = {3'($urandom_range(0, 7)), drop_type_now};
            2:       hdr = ZERO_BYTE;
            default: hdr = 8'($urandom_range(0, 255));
        endcase
        stream_byte(hdr);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
        repeat (len)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: stream_byte(ZERO_BYTE);
                3:       stream_byte(ONE_BYTE);
                4:
                begin
                    // Two zeros followed by a byte that is not a start code.
                    stream_byte(ZERO_BYTE);
                    stream_byte(ZERO_BYTE);
                    stream_byte(8'($urandom_range(2, 3)));
                end
                5:       repeat (3) stream_byte(ZERO_BYTE);
                default: stream_byte(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) stream_byte(ZERO_BYTE);
    endtask

    task automatic random_phase(input logic flush);
        random_beats = 0;
        while (random_beats < PHASE_BYTES)
            send_unit();
        if (flush)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
    endtask

    initial
    begin
        logic [7:0] lead_in[$];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stream under the reset drop setting.
        lead_in = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h7F,
                    8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09,
                    8'hF0, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        foreach (lead_in[i])
            send_byte(lead_in[i], i == lead_in.size() - 1);
        // End of stream right after a start code.
        send_byte(ZERO_BYTE, 1'b0);
        send_byte(ZERO_BYTE, 1'b0);
        send_byte(ONE_BYTE, 1'b1);
        wait_idle();

        // Dropping off, type register at its top value.
        write_reg(REG_DROP_ENABLE, 8'h00);
        write_reg(REG_DROP_TYPE, 8'd31);
        drop_type_now = 5'd31;
        random_phase(1'b0);

        // Drop type 0; the open unit keeps its earlier decision.
        write_reg(REG_DROP_ENABLE, 8'h01);
        write_reg(REG_DROP_TYPE, 8'd0);
        drop_type_now = 5'd0;
        random_phase(1'b1);

        // Unused index is ignored; upper data bits are ignored.
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_DROP_ENABLE, 8'hFF);
        write_reg(REG_DROP_TYPE, 8'hFF);
        drop_type_now = 5'd31;
        random_phase(1'b0);

        write_reg(REG_DROP_TYPE, 8'($urandom_range(1, 30)));
        drop_type_now = cfg_data[4:0];
        random_phase(1'b1);

        drain <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d stream bytes and %0d register writes sent, %0d unit bytes seen",
                 in_beats, cfg_writes, out_beats);
        $display("tb_top: drop off, drop types 0, 9, 31 and %0d, with bursts and stalls",
                 drop_type_now);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
